// ===== design/oldq_pkg.sv =====
// shared types and constants for the ordered list deque search block
package oldq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 40;

   typedef enum logic [2:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_REMOVE     = 3'd4,
      MODE_SEARCH     = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic {
      STATE_IDLE  = 1'b0,
      STATE_APPLY = 1'b1
   } state_type;

   typedef struct packed {
      logic capture;
      logic apply;
   } cmd_type;

endpackage

// ===== design/oldq_ctrl.sv =====
// controller: sequences capture and apply of one word and holds the output valid
module oldq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output oldq_pkg::cmd_type cmd
);

   oldq_pkg::state_type state_ff, state_in;
   logic                out_valid_ff, out_valid_in;
   logic                apply_go;

   assign apply_go = (state_ff == oldq_pkg::STATE_APPLY) && (!out_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         oldq_pkg::STATE_IDLE: begin
            if (req_tvalid) state_in = oldq_pkg::STATE_APPLY;
         end
         oldq_pkg::STATE_APPLY: begin
            if (apply_go) state_in = oldq_pkg::STATE_IDLE;
         end
         default: state_in = oldq_pkg::STATE_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = (state_ff == oldq_pkg::STATE_IDLE);
      cmd.capture = req_tvalid && (state_ff == oldq_pkg::STATE_IDLE);
      cmd.apply   = apply_go;
      rsp_tvalid  = out_valid_ff;
      if (apply_go) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oldq_pkg::STATE_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== design/oldq_datapath.sv =====
// datapath: chain of entry cells with parallel compare, shift network and result registers
module oldq_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  oldq_pkg::cmd_type            cmd,
   input  logic [2:0]                   req_mode,
   input  logic [oldq_pkg::VALUE_W-1:0] req_value,
   output logic [oldq_pkg::VALUE_W-1:0] rsp_value,
   output logic [1:0]                   rsp_status,
   output logic [4:0]                   rsp_count
);

   localparam int CAP = oldq_pkg::CAPACITY;
   localparam int CW  = oldq_pkg::CNT_W;
   localparam int VW  = oldq_pkg::VALUE_W;

   logic [VW-1:0]  entries_ff [CAP];
   logic [VW-1:0]  entries_in [CAP];
   logic [VW-1:0]  shift_up   [CAP];
   logic [VW-1:0]  shift_down [CAP];
   logic [CW-1:0]  count_ff, count_in;
   logic [2:0]     mode_ff;
   logic [VW-1:0]  value_ff;
   logic [CAP-1:0] match_ff, match_in;
   logic [CAP-1:0] first_oh, from_pos;
   logic           found, full, empty;
   logic [VW-1:0]  res_in;
   logic [1:0]     status_in;
   logic [CW+4:0]  count_wide;
   logic [VW-1:0]  rsp_value_ff;
   logic [1:0]     rsp_status_ff;
   logic [4:0]     rsp_count_ff;

   // neighbor taps of the cell chain
   for (genvar g = 0; g < CAP; g++) begin : g_taps
      if (g == 0) begin : g_first
         assign shift_up[g] = value_ff;
      end else begin : g_rest
         assign shift_up[g] = entries_ff[g-1];
      end
      if (g == CAP - 1) begin : g_last
         assign shift_down[g] = entries_ff[g];
      end else begin : g_mid
         assign shift_down[g] = entries_ff[g+1];
      end
   end

   // every held cell compares against the incoming word
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         match_in[i] = (entries_ff[i] == req_value) && (CW'(i) < count_ff);
      end
   end

   assign first_oh = match_ff & (~match_ff + CAP'(1));
   assign from_pos = ~(first_oh - CAP'(1));
   assign found    = |match_ff;
   assign full     = (count_ff == CW'(CAP));
   assign empty    = (count_ff == '0);

   always_comb begin
      entries_in = entries_ff;
      count_in   = count_ff;
      res_in     = '0;
      status_in  = oldq_pkg::STATUS_OK;
      case (oldq_pkg::mode_type'(mode_ff))
         oldq_pkg::MODE_PUSH_FRONT: begin
            if (full) begin
               status_in = oldq_pkg::STATUS_FULL;
            end else begin
               entries_in = shift_up;
               count_in   = count_ff + CW'(1);
            end
         end
         oldq_pkg::MODE_PUSH_BACK: begin
            if (full) begin
               status_in = oldq_pkg::STATUS_FULL;
            end else begin
               for (int i = 0; i < CAP; i++) begin
                  if (CW'(i) == count_ff) entries_in[i] = value_ff;
               end
               count_in = count_ff + CW'(1);
            end
         end
         oldq_pkg::MODE_POP_FRONT: begin
            if (empty) begin
               status_in = oldq_pkg::STATUS_EMPTY;
            end else begin
               res_in     = entries_ff[0];
               entries_in = shift_down;
               count_in   = count_ff - CW'(1);
            end
         end
         oldq_pkg::MODE_POP_BACK: begin
            if (empty) begin
               status_in = oldq_pkg::STATUS_EMPTY;
            end else begin
               for (int i = 0; i < CAP; i++) begin
                  if (CW'(i) == count_ff - CW'(1)) res_in = entries_ff[i];
               end
               count_in = count_ff - CW'(1);
            end
         end
         oldq_pkg::MODE_REMOVE: begin
            if (empty) begin
               status_in = oldq_pkg::STATUS_EMPTY;
            end else if (found) begin
               // cells at and behind the first match close the gap
               for (int i = 0; i < CAP; i++) begin
                  if (from_pos[i]) entries_in[i] = shift_down[i];
               end
               count_in = count_ff - CW'(1);
            end else begin
               status_in = oldq_pkg::STATUS_NOT_FOUND;
            end
         end
         oldq_pkg::MODE_SEARCH: begin
            if (!found) status_in = oldq_pkg::STATUS_NOT_FOUND;
         end
         default: ;
      endcase
   end

   assign count_wide = {5'b0, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.apply) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         value_ff <= req_value;
         match_ff <= match_in;
      end
      if (cmd.apply) begin
         entries_ff    <= entries_in;
         rsp_value_ff  <= res_in;
         rsp_status_ff <= status_in;
         rsp_count_ff  <= count_wide[4:0];
      end
   end

   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

// ===== design/ordered_list_deque_search.sv =====
// top level of the ordered list deque search block
//
// bounded ordered list of signed 32-bit values held in a chain of cells.
// the req_ channel carries one operation word: push front, push back, pop
// front, pop back, remove first equal value, or search. the rsp_ channel
// returns exactly one word per operation: popped value (zero otherwise),
// status (ok, empty, full, not found) and the entry count afterwards.
// each operation runs in a capture step and an apply step: the accept edge
// registers the compare of the value against every held cell, the apply
// edge shifts the cell chain and loads the output register, which makes the
// result valid. a new word is taken only once the last one has passed its
// apply step.
// the output register parts the two sides; if a result still waits when
// the next one is ready, the block holds in its apply step until rsp_tready
// frees the register, and req_tready stays low meanwhile.
// synchronous reset empties the list and drops any pending result; cell
// contents are left as they are and are never read before being written.
module ordered_list_deque_search (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [oldq_pkg::REQ_W-1:0]  req_tdata,  // mode[2:0], value[34:3], zero pad
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [oldq_pkg::RSP_W-1:0]  rsp_tdata   // result_value[31:0], status[33:32],
                                                   // entry_count[38:34], zero pad
);

   oldq_pkg::cmd_type cmd;
   logic [31:0]       rsp_value;
   logic [1:0]        rsp_status;
   logic [4:0]        rsp_count;

   oldq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   oldq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_mode   (req_tdata[2:0]),
      .req_value  (req_tdata[34:3]),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

   assign rsp_tdata = {1'b0, rsp_count, rsp_status, rsp_value};

endmodule

// ===== design/oldq_checker.sv =====
// port-level checks for the ordered list deque search block, bound to the top level
module oldq_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [oldq_pkg::RSP_W-1:0]  rsp_tdata
);

   logic req_fire;
   assign req_fire = req_tvalid && req_tready;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one operation at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request taken while previous operation busy");

   // a request accepted with a free output register yields a result without a stall
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_fire && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("result missing two cycles after request");

   // a full status only when the list is at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[33:32] == oldq_pkg::STATUS_FULL)
      |-> rsp_tdata[38:34] == 5'(oldq_pkg::CAPACITY))
      else $error("full status with list below capacity");

endmodule

bind ordered_list_deque_search oldq_checker u_oldq_checker (.*);
